// ----- rtl/core/kmd_pkg.sv -----
// ----------------------------------------------------------------------------
// kmd_pkg
// Types and constants shared by the key matrix debounce modules.
// ----------------------------------------------------------------------------
package kmd_pkg;

    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int ROW_W  = 4;
    localparam int COL_W  = 7;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd10;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE         = 4'b0001,
        PH_PRESS_LOCK   = 4'b0010,
        PH_PRESSED      = 4'b0100,
        PH_RELEASE_LOCK = 4'b1000
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [TIME_W-1:0]   stamp;
    } t_key_state;

endpackage

// ----- rtl/core/kmd_item_if.sv -----
// ----------------------------------------------------------------------------
// kmd_item_if
// Input channel: row samples and millisecond ticks.
// ----------------------------------------------------------------------------
interface kmd_item_if
    import kmd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             action;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] columns;

    modport source (output valid, action, row, columns, input ready);
    modport sink   (input valid, action, row, columns, output ready);
endinterface

// ----- rtl/core/kmd_result_if.sv -----
// ----------------------------------------------------------------------------
// kmd_result_if
// Output channel: debounced pressed bits of one row.
// ----------------------------------------------------------------------------
interface kmd_result_if
    import kmd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row_out;
    logic [COL_W-1:0] pressed;

    modport source (output valid, row_out, pressed, input ready);
    modport sink   (input valid, row_out, pressed, output ready);
endinterface

// ----- rtl/core/kmd_lane.sv -----
// ----------------------------------------------------------------------------
// kmd_lane
// Next-state logic of one key's four-phase debounce machine.
// ----------------------------------------------------------------------------
module kmd_lane
    import kmd_pkg::*;
(
    input  t_key_state        i_state,
    input  logic              i_raw,
    input  logic [TIME_W-1:0] i_now,
    input  logic [CFG_W-1:0]  i_debounce,
    output t_key_state        o_state,
    output logic              o_pressed
);

    logic [TIME_W-1:0] elapsed;
    logic              expired;

    assign elapsed = i_now - i_state.stamp;
    assign expired = elapsed >= TIME_W'(i_debounce);

    always_comb begin
        o_state   = i_state;
        o_pressed = 1'b0;
        unique case (i_state.phase)
            PH_IDLE: begin
                if (i_raw) begin
                    o_state.phase = PH_PRESS_LOCK;
                    o_state.stamp = i_now;
                    o_pressed     = 1'b1;
                end
            end
            PH_PRESS_LOCK: begin
                o_pressed = 1'b1;
                if (expired) begin
                    o_state.phase = PH_PRESSED;
                end
            end
            PH_PRESSED: begin
                if (i_raw) begin
                    o_pressed = 1'b1;
                end else begin
                    o_state.phase = PH_RELEASE_LOCK;
                    o_state.stamp = i_now;
                end
            end
            PH_RELEASE_LOCK: begin
                if (expired) begin
                    o_state.phase = PH_IDLE;
                end
            end
            default: begin
                o_state.phase = PH_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/kmd_merge.sv -----
// ----------------------------------------------------------------------------
// kmd_merge
// Gathers the lanes' pressed bits into one result item and holds it in the
// output register until the sink takes it.
// ----------------------------------------------------------------------------
module kmd_merge
    import kmd_pkg::*;
#(
    parameter int COLS = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [ROW_W-1:0]  i_row,
    input  logic [COLS-1:0]   i_lane_pressed,
    output logic              o_ready,
    kmd_result_if.source      o_result
);

    logic             r_valid;
    logic             n_valid;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_pressed;

    assign o_ready = !r_valid || o_result.ready;
    assign n_valid = i_load || (r_valid && !o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_row     <= i_row;
            r_pressed <= COL_W'(i_lane_pressed);
        end
    end

    assign o_result.valid   = r_valid;
    assign o_result.row_out = r_row;
    assign o_result.pressed = r_pressed;

endmodule

// ----- rtl/core/key_matrix_debounce.sv -----
// ----------------------------------------------------------------------------
// A row sample's result is registered and valid in the cycle after the item is accepted.
// One item per cycle if not stalled; all keys of a row update in the same cycle.
// Ticks and samples of rows beyond the matrix are accepted and give no result.
// Reset puts every key idle with a zero stamp, clears the millisecond counter
// and loads a debounce time of 10 ms; the block is ready right after reset.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// key_matrix_debounce
// Per-key debounce of a scanned key matrix, one lane per column.
// ----------------------------------------------------------------------------
module key_matrix_debounce
    import kmd_pkg::*;
#(
    parameter int ROWS = 15,
    parameter int COLS = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    kmd_item_if.sink         i_item,
    kmd_result_if.source     o_result
);

    localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int RXW = RW + ROW_W;

    t_key_state        r_state [ROWS][COLS];
    t_key_state        n_state [COLS];
    logic [TIME_W-1:0] r_ms;
    logic [CFG_W-1:0]  r_debounce;

    logic              merge_ready;
    logic              accept;
    logic              sample_ok;
    logic [RXW-1:0]    row_ext;
    logic [RW-1:0]     row_idx;
    logic [COLS-1:0]   raw;
    logic [COLS-1:0]   lane_pressed;

    assign i_item.ready = merge_ready;
    assign accept       = i_item.valid && merge_ready;
    assign row_ext      = RXW'(i_item.row);
    assign row_idx      = row_ext[RW-1:0];
    assign sample_ok    = accept && (i_item.action == ACT_SAMPLE)
                          && (row_ext < RXW'(ROWS));
    assign raw          = COLS'({1'b0, i_item.columns});

    for (genvar c = 0; c < COLS; c++) begin : g_lane
        kmd_lane u_lane (
            .i_state    (r_state[row_idx][c]),
            .i_raw      (raw[c]),
            .i_now      (r_ms),
            .i_debounce (r_debounce),
            .o_state    (n_state[c]),
            .o_pressed  (lane_pressed[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                for (int c = 0; c < COLS; c++) begin
                    r_state[r][c] <= '{phase: PH_IDLE, stamp: '0};
                end
            end
        end else if (sample_ok) begin
            for (int c = 0; c < COLS; c++) begin
                r_state[row_idx][c] <= n_state[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms <= '0;
        end else if (accept && (i_item.action == ACT_TICK)) begin
            r_ms <= r_ms + TIME_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            r_debounce <= i_cfg_wdata;
        end
    end

    kmd_merge #(
        .COLS (COLS)
    ) u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (sample_ok),
        .i_row          (i_item.row),
        .i_lane_pressed (lane_pressed),
        .o_ready        (merge_ready),
        .o_result       (o_result)
    );

endmodule
